### hdl/voxel_label_vote_and_iou_count_core_macros.svh
// Assertion macros used by the checker file.
`ifndef VOXEL_LABEL_VOTE_AND_IOU_COUNT_CORE_MACROS_SVH
`define VOXEL_LABEL_VOTE_AND_IOU_COUNT_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define VLVIC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define VLVIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/vlvic_pkg.sv
// ----------------------------------------------------------------------------
// vlvic_pkg
// Types and constants of the voxel vote and IoU counting core.
// ----------------------------------------------------------------------------
package vlvic_pkg;

    localparam int VOXEL_CAPACITY = 4096;
    localparam int ADDR_W         = $clog2(VOXEL_CAPACITY);
    localparam int USED_W         = ADDR_W + 1;
    localparam int CLASS_COUNT    = 9;
    localparam int CLS_W          = 4;
    localparam int COORD_W        = 24;
    localparam int EDGE_W         = 16;
    localparam int VOTE_W         = 16;
    localparam int CNT_W          = 32;
    localparam int DIV_STEP_W     = 5;
    localparam logic [EDGE_W-1:0] EDGE_RESET = 16'd70;

    typedef enum logic [1:0] {
        CMD_VOTE  = 2'd0,
        CMD_EVAL  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_HASH,
        ST_PROBE_RD,
        ST_PROBE_CMP,
        ST_VWRITE,
        ST_ARGMAX,
        ST_UPD_LAB,
        ST_UPD_PRED,
        ST_READ,
        ST_CLR,
        ST_RESP
    } state_t;

    typedef logic [CLASS_COUNT-1:0][VOTE_W-1:0] vote_row_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } key_entry_t;

endpackage

### hdl/vlvic_in_if.sv
// ----------------------------------------------------------------------------
// vlvic_in_if
// Input channel: one command beat with point and label.
// ----------------------------------------------------------------------------
interface vlvic_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          cmd;
    logic signed [vlvic_pkg::COORD_W-1:0] coord_x;
    logic signed [vlvic_pkg::COORD_W-1:0] coord_y;
    logic signed [vlvic_pkg::COORD_W-1:0] coord_z;
    logic [vlvic_pkg::CLS_W-1:0]          class_label;

    modport source (output valid, cmd, coord_x, coord_y, coord_z, class_label,
                    input ready);
    modport sink   (input valid, cmd, coord_x, coord_y, coord_z, class_label,
                    output ready);
endinterface

### hdl/vlvic_out_if.sv
// ----------------------------------------------------------------------------
// vlvic_out_if
// Output channel: one result beat per command.
// ----------------------------------------------------------------------------
interface vlvic_out_if;
    logic                        valid;
    logic                        ready;
    logic                        table_full;
    logic                        skipped;
    logic [vlvic_pkg::CLS_W-1:0] predicted_label;
    logic [vlvic_pkg::CNT_W-1:0] success_count;
    logic [vlvic_pkg::CNT_W-1:0] union_count;
    logic [vlvic_pkg::CNT_W-1:0] labeled_count;

    modport source (output valid, table_full, skipped, predicted_label,
                    success_count, union_count, labeled_count, input ready);
    modport sink   (input valid, table_full, skipped, predicted_label,
                    success_count, union_count, labeled_count, output ready);
endinterface

### hdl/voxel_label_vote_and_iou_count_core.sv
// One command at a time: the radix-2 divider and the linear-probe walk over
// the key memory run before the next command is accepted.
// Reset: asynchronous, active low; after release a sweep over all 4096 slots
// clears the key memory while in_ch.ready stays low.
// ----------------------------------------------------------------------------
// voxel_label_vote_and_iou_count_core
// Voxel majority vote table with per-class IoU counters, built around
// a key memory and a vote-row memory addressed by a hashed voxel index.
// ----------------------------------------------------------------------------
module voxel_label_vote_and_iou_count_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vlvic_pkg::EDGE_W-1:0]        cfg_wdata,
    vlvic_in_if.sink                            in_ch,
    vlvic_out_if.source                         out_ch
);

    localparam int AW = vlvic_pkg::ADDR_W;
    localparam int CW = vlvic_pkg::COORD_W;
    localparam int NC = vlvic_pkg::CLASS_COUNT;

    // Memories: key per slot, vote row per slot (same address).
    vlvic_pkg::key_entry_t key_mem [vlvic_pkg::VOXEL_CAPACITY];
    vlvic_pkg::vote_row_t  vote_mem [vlvic_pkg::VOXEL_CAPACITY];

    vlvic_pkg::state_t state_reg, state_next;

    logic [vlvic_pkg::EDGE_W-1:0] voxel_edge_reg;
    logic [vlvic_pkg::EDGE_W-1:0] div_edge_reg;
    vlvic_pkg::cmd_t              cmd_reg;
    logic [vlvic_pkg::CLS_W-1:0]  lab_reg;

    // Divider state, one lane per axis.
    logic [CW-1:0]                mag_reg [3];
    logic [vlvic_pkg::EDGE_W:0]   rem_reg [3];
    logic [CW-1:0]                quo_reg [3];
    logic                         neg_reg [3];
    logic [vlvic_pkg::DIV_STEP_W-1:0] step_reg;

    logic [CW-1:0]                key_x_reg, key_y_reg, key_z_reg;
    logic [AW-1:0]                probe_addr_reg;
    logic [vlvic_pkg::USED_W-1:0] probe_cnt_reg;
    logic [vlvic_pkg::USED_W-1:0] entries_used_reg;
    logic [AW-1:0]                clr_addr_reg;
    logic                         clr_resp_reg;

    vlvic_pkg::key_entry_t key_rd_reg;
    vlvic_pkg::vote_row_t  vote_rd_reg;

    logic [vlvic_pkg::CLS_W-1:0]  pred_reg;
    logic [vlvic_pkg::CNT_W-1:0]  succ_reg [NC];
    logic [vlvic_pkg::CNT_W-1:0]  uni_reg [NC];
    logic [vlvic_pkg::CNT_W-1:0]  labeled_reg;

    // Result being built, then the output register.
    logic                         res_full_reg, res_skip_reg;
    logic [vlvic_pkg::CLS_W-1:0]  res_pred_reg;
    logic [vlvic_pkg::CNT_W-1:0]  res_succ_reg, res_uni_reg, res_lab_reg;
    logic                         out_valid_reg;
    logic                         out_full_reg, out_skip_reg;
    logic [vlvic_pkg::CLS_W-1:0]  out_pred_reg;
    logic [vlvic_pkg::CNT_W-1:0]  out_succ_reg, out_uni_reg, out_lab_reg;

    // Combinational controls.
    logic                         in_fire;
    logic                         key_we, vote_we;
    vlvic_pkg::key_entry_t        key_wdata;
    vlvic_pkg::vote_row_t         vote_wdata;
    logic [AW-1:0]                mem_waddr;
    logic [vlvic_pkg::CLS_W-1:0]  cls_addr;
    logic                         inc_succ, inc_uni, inc_labeled, clr_counters;
    logic                         hit, slot_empty, probes_done, lab_ok;
    logic [CW-1:0]                idx [3];
    logic [AW-1:0]                hash;
    logic [vlvic_pkg::CLS_W-1:0]  argmax;
    logic [vlvic_pkg::VOTE_W-1:0] best;
    logic                         out_free;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == vlvic_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign lab_ok   = (lab_reg < vlvic_pkg::CLS_W'(NC));

    // Quantization divides the magnitude: a negative coordinate gives
    // -(|c|/e), plus one when the division is exact.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (neg_reg[a])
                idx[a] = (~quo_reg[a] + CW'(1)) + CW'(rem_reg[a] == '0);
            else
                idx[a] = quo_reg[a];
        end
    end

    // Fold the three indices into a table slot.
    assign hash = idx[0][AW-1:0] ^ idx[0][CW-1:CW-AW]
                ^ {idx[1][AW/2-1:0], idx[1][AW-1:AW/2]} ^ idx[1][CW-1:CW-AW]
                ^ {idx[2][2:0], idx[2][AW-1:3]} ^ idx[2][CW-1:CW-AW];

    assign hit = key_rd_reg.valid && key_rd_reg.x == key_x_reg
              && key_rd_reg.y == key_y_reg && key_rd_reg.z == key_z_reg;
    assign slot_empty  = !key_rd_reg.valid;
    assign probes_done = (probe_cnt_reg == vlvic_pkg::USED_W'(vlvic_pkg::VOXEL_CAPACITY - 1));

    // Lowest label wins ties: only a strictly larger count moves the pick.
    always_comb
    begin
        argmax = '0;
        best   = vote_rd_reg[0];
        for (int c = 1; c < NC; c++)
        begin
            if (vote_rd_reg[c] > best)
            begin
                best   = vote_rd_reg[c];
                argmax = vlvic_pkg::CLS_W'(c);
            end
        end
    end

    // Next state and datapath strobes.
    always_comb
    begin
        state_next   = state_reg;
        key_we       = 1'b0;
        vote_we      = 1'b0;
        key_wdata    = '0;
        vote_wdata   = vote_rd_reg;
        mem_waddr    = probe_addr_reg;
        cls_addr     = lab_reg;
        inc_succ     = 1'b0;
        inc_uni      = 1'b0;
        inc_labeled  = 1'b0;
        clr_counters = 1'b0;
        unique case (state_reg)
            vlvic_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (vlvic_pkg::cmd_t'(in_ch.cmd))
                        vlvic_pkg::CMD_CLEAR:
                        begin
                            clr_counters = 1'b1;
                            state_next   = vlvic_pkg::ST_CLR;
                        end
                        vlvic_pkg::CMD_READ:
                            state_next = vlvic_pkg::ST_READ;
                        vlvic_pkg::CMD_VOTE:
                            state_next = (in_ch.class_label < vlvic_pkg::CLS_W'(NC))
                                       ? vlvic_pkg::ST_DIV : vlvic_pkg::ST_RESP;
                        vlvic_pkg::CMD_EVAL:
                            state_next = (in_ch.class_label != '0 &&
                                          in_ch.class_label < vlvic_pkg::CLS_W'(NC))
                                       ? vlvic_pkg::ST_DIV : vlvic_pkg::ST_RESP;
                        default:
                            state_next = vlvic_pkg::ST_RESP;
                    endcase
                end
            end
            vlvic_pkg::ST_DIV:
                if (step_reg == vlvic_pkg::DIV_STEP_W'(CW - 1))
                    state_next = vlvic_pkg::ST_HASH;
            vlvic_pkg::ST_HASH:
                state_next = vlvic_pkg::ST_PROBE_RD;
            vlvic_pkg::ST_PROBE_RD:
                state_next = vlvic_pkg::ST_PROBE_CMP;
            vlvic_pkg::ST_PROBE_CMP:
            begin
                if (hit)
                    state_next = (cmd_reg == vlvic_pkg::CMD_VOTE)
                               ? vlvic_pkg::ST_VWRITE : vlvic_pkg::ST_ARGMAX;
                else if (slot_empty || probes_done)
                begin
                    if (cmd_reg == vlvic_pkg::CMD_VOTE)
                    begin
                        // Allocate the empty slot unless the table is full.
                        if (entries_used_reg !=
                            vlvic_pkg::USED_W'(vlvic_pkg::VOXEL_CAPACITY))
                        begin
                            key_we          = 1'b1;
                            key_wdata.valid = 1'b1;
                            key_wdata.x     = key_x_reg;
                            key_wdata.y     = key_y_reg;
                            key_wdata.z     = key_z_reg;
                            vote_we         = 1'b1;
                            vote_wdata      = '0;
                            vote_wdata[lab_reg] = vlvic_pkg::VOTE_W'(1);
                        end
                        state_next = vlvic_pkg::ST_RESP;
                    end
                    else
                        state_next = vlvic_pkg::ST_UPD_LAB;
                end
                else
                    state_next = vlvic_pkg::ST_PROBE_RD;
            end
            vlvic_pkg::ST_VWRITE:
            begin
                vote_we = 1'b1;
                if (vote_rd_reg[lab_reg] != '1)
                    vote_wdata[lab_reg] = vote_rd_reg[lab_reg] + vlvic_pkg::VOTE_W'(1);
                state_next = vlvic_pkg::ST_RESP;
            end
            vlvic_pkg::ST_ARGMAX:
                state_next = vlvic_pkg::ST_UPD_LAB;
            vlvic_pkg::ST_UPD_LAB:
            begin
                inc_labeled = 1'b1;
                inc_uni     = 1'b1;
                inc_succ    = (pred_reg == lab_reg);
                state_next  = (pred_reg == lab_reg)
                            ? vlvic_pkg::ST_RESP : vlvic_pkg::ST_UPD_PRED;
            end
            vlvic_pkg::ST_UPD_PRED:
            begin
                cls_addr   = pred_reg;
                inc_uni    = 1'b1;
                state_next = vlvic_pkg::ST_RESP;
            end
            vlvic_pkg::ST_READ:
                state_next = vlvic_pkg::ST_RESP;
            vlvic_pkg::ST_CLR:
            begin
                key_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == '1)
                    state_next = clr_resp_reg ? vlvic_pkg::ST_RESP : vlvic_pkg::ST_IDLE;
            end
            vlvic_pkg::ST_RESP:
                if (out_free)
                    state_next = vlvic_pkg::ST_IDLE;
            default:
                state_next = vlvic_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= vlvic_pkg::ST_CLR;
        else
            state_reg <= state_next;
    end

    // Memory ports: one write, one registered read at the probe address.
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[mem_waddr] <= key_wdata;
        key_rd_reg <= key_mem[probe_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (vote_we)
            vote_mem[mem_waddr] <= vote_wdata;
        vote_rd_reg <= vote_mem[probe_addr_reg];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voxel_edge_reg   <= vlvic_pkg::EDGE_RESET;
            clr_addr_reg     <= '0;
            clr_resp_reg     <= 1'b0;
            entries_used_reg <= '0;
            labeled_reg      <= '0;
            out_valid_reg    <= 1'b0;
            for (int c = 0; c < NC; c++)
            begin
                succ_reg[c] <= '0;
                uni_reg[c]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                voxel_edge_reg <= cfg_wdata;
            if (state_reg == vlvic_pkg::ST_CLR)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            if (in_fire)
                clr_resp_reg <= (vlvic_pkg::cmd_t'(in_ch.cmd) == vlvic_pkg::CMD_CLEAR);
            if (clr_counters)
            begin
                entries_used_reg <= '0;
                labeled_reg      <= '0;
                for (int c = 0; c < NC; c++)
                begin
                    succ_reg[c] <= '0;
                    uni_reg[c]  <= '0;
                end
            end
            else
            begin
                if (key_we && state_reg == vlvic_pkg::ST_PROBE_CMP)
                    entries_used_reg <= entries_used_reg + vlvic_pkg::USED_W'(1);
                if (inc_labeled && labeled_reg != '1)
                    labeled_reg <= labeled_reg + vlvic_pkg::CNT_W'(1);
                if (inc_succ && succ_reg[cls_addr] != '1)
                    succ_reg[cls_addr] <= succ_reg[cls_addr] + vlvic_pkg::CNT_W'(1);
                if (inc_uni && uni_reg[cls_addr] != '1)
                    uni_reg[cls_addr] <= uni_reg[cls_addr] + vlvic_pkg::CNT_W'(1);
            end
            // Hold the beat until taken; a new result loads only when free.
            if (state_reg == vlvic_pkg::ST_RESP && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg      <= vlvic_pkg::cmd_t'(in_ch.cmd);
            lab_reg      <= in_ch.class_label;
            div_edge_reg <= (voxel_edge_reg == '0) ? vlvic_pkg::EDGE_W'(1) : voxel_edge_reg;
            neg_reg[0]   <= in_ch.coord_x[CW-1];
            neg_reg[1]   <= in_ch.coord_y[CW-1];
            neg_reg[2]   <= in_ch.coord_z[CW-1];
            mag_reg[0]   <= in_ch.coord_x[CW-1] ? -in_ch.coord_x : in_ch.coord_x;
            mag_reg[1]   <= in_ch.coord_y[CW-1] ? -in_ch.coord_y : in_ch.coord_y;
            mag_reg[2]   <= in_ch.coord_z[CW-1] ? -in_ch.coord_z : in_ch.coord_z;
            for (int a = 0; a < 3; a++)
            begin
                rem_reg[a] <= '0;
                quo_reg[a] <= '0;
            end
            step_reg     <= '0;
            res_full_reg <= 1'b0;
            res_skip_reg <= (vlvic_pkg::cmd_t'(in_ch.cmd) == vlvic_pkg::CMD_EVAL) &&
                            (in_ch.class_label == '0 ||
                             in_ch.class_label >= vlvic_pkg::CLS_W'(NC));
            res_pred_reg <= '0;
            res_succ_reg <= '0;
            res_uni_reg  <= '0;
            res_lab_reg  <= '0;
            pred_reg     <= '0;
        end
        // One restoring-division bit per cycle on each axis.
        if (state_reg == vlvic_pkg::ST_DIV)
        begin
            step_reg <= step_reg + vlvic_pkg::DIV_STEP_W'(1);
            for (int a = 0; a < 3; a++)
            begin
                if ({rem_reg[a][vlvic_pkg::EDGE_W-1:0], mag_reg[a][CW-1]} >=
                    {1'b0, div_edge_reg})
                begin
                    rem_reg[a] <= {rem_reg[a][vlvic_pkg::EDGE_W-1:0], mag_reg[a][CW-1]}
                                - {1'b0, div_edge_reg};
                    quo_reg[a] <= {quo_reg[a][CW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[a] <= {rem_reg[a][vlvic_pkg::EDGE_W-1:0], mag_reg[a][CW-1]};
                    quo_reg[a] <= {quo_reg[a][CW-2:0], 1'b0};
                end
                mag_reg[a] <= {mag_reg[a][CW-2:0], 1'b0};
            end
        end
        if (state_reg == vlvic_pkg::ST_HASH)
        begin
            key_x_reg      <= idx[0];
            key_y_reg      <= idx[1];
            key_z_reg      <= idx[2];
            probe_addr_reg <= hash;
            probe_cnt_reg  <= '0;
        end
        if (state_reg == vlvic_pkg::ST_PROBE_CMP && !hit && !slot_empty && !probes_done)
        begin
            probe_addr_reg <= probe_addr_reg + AW'(1);
            probe_cnt_reg  <= probe_cnt_reg + vlvic_pkg::USED_W'(1);
        end
        if (state_reg == vlvic_pkg::ST_PROBE_CMP && !hit && (slot_empty || probes_done) &&
            cmd_reg == vlvic_pkg::CMD_VOTE &&
            entries_used_reg == vlvic_pkg::USED_W'(vlvic_pkg::VOXEL_CAPACITY))
            res_full_reg <= 1'b1;
        if (state_reg == vlvic_pkg::ST_ARGMAX)
            pred_reg <= argmax;
        if (state_reg == vlvic_pkg::ST_UPD_LAB)
            res_pred_reg <= pred_reg;
        if (state_reg == vlvic_pkg::ST_READ)
        begin
            res_succ_reg <= lab_ok ? succ_reg[cls_addr] : '0;
            res_uni_reg  <= lab_ok ? uni_reg[cls_addr] : '0;
            res_lab_reg  <= labeled_reg;
        end
        if (state_reg == vlvic_pkg::ST_RESP && out_free)
        begin
            out_full_reg <= res_full_reg;
            out_skip_reg <= res_skip_reg;
            out_pred_reg <= res_pred_reg;
            out_succ_reg <= res_succ_reg;
            out_uni_reg  <= res_uni_reg;
            out_lab_reg  <= res_lab_reg;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.table_full      = out_full_reg;
    assign out_ch.skipped         = out_skip_reg;
    assign out_ch.predicted_label = out_pred_reg;
    assign out_ch.success_count   = out_succ_reg;
    assign out_ch.union_count     = out_uni_reg;
    assign out_ch.labeled_count   = out_lab_reg;

endmodule

### hdl/vlvic_checker.sv
// ----------------------------------------------------------------------------
// vlvic_checker
// Port-level checks on the voxel vote core, bound to the top level.
// ----------------------------------------------------------------------------
`include "voxel_label_vote_and_iou_count_core_macros.svh"

module vlvic_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        table_full,
    input logic                        skipped,
    input logic [vlvic_pkg::CLS_W-1:0] predicted_label,
    input logic [vlvic_pkg::CNT_W-1:0] success_count
);

    `VLVIC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `VLVIC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `VLVIC_ASSERT_NOW(a_flags_exclusive, clk, rst_n, out_valid, !(table_full && skipped))
    `VLVIC_ASSERT_NOW(a_skip_clean, clk, rst_n, out_valid && skipped,
                      predicted_label == '0 && success_count == '0)

endmodule

bind voxel_label_vote_and_iou_count_core vlvic_checker u_vlvic_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .table_full      (out_ch.table_full),
    .skipped         (out_ch.skipped),
    .predicted_label (out_ch.predicted_label),
    .success_count   (out_ch.success_count)
);
